>>> rtl/tvwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvwt_pkg
// Shared types and constants of the tolerant vertex weld table.
// ----------------------------------------------------------------------------
package tvwt_pkg;

  localparam int unsigned BucketsDef   = 128;
  localparam int unsigned MaxUniqueDef = 4096;

  localparam int unsigned CoordW = 32;
  localparam int unsigned TolW   = 31;
  localparam int unsigned IndexW = 12;
  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 32;

  // z offset times scale is Q.24 above the bucket number
  localparam int unsigned ProdW     = 64;
  localparam int unsigned BucketLsb = 24;

  localparam logic [TolW-1:0]   TolRst   = TolW'(128);
  localparam logic [CoordW-1:0] ZOrgRst  = '0;
  localparam logic [31:0]       ScaleRst = 32'd65536;

  // register word index, byte address 4*i
  typedef enum logic [1:0] {
    REG_MERGE_TOL    = 2'd0,
    REG_Z_ORIGIN     = 2'd1,
    REG_BUCKET_SCALE = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_BKT,
    ST_HEAD,
    ST_WALK,
    ST_INSERT,
    ST_DONE
  } state_e;

endpackage

>>> rtl/tolerant_vertex_weld_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tolerant_vertex_weld_table
// Welds vertices within a per-axis tolerance through a z-bucketed hash of
// chains, returning the index of the matching or newly stored vertex, or store_full when full.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake           Payload
// s_axis    in   tvalid/tready       tdata: coord_x, coord_y, coord_z
// m_axis    out  tvalid/tready       tdata: vertex_index; tuser: is_new, store_full
// apb       in   psel/penable/pready merge_tolerance @0, z_origin @4, bucket_scale @8
//
// An accepted item passes MUL, BKT and HEAD, then WALK for each chain entry visited
// (one node-memory read each), INSERT when it ends without a match, and DONE.
// After reset a clearing pass writes every bucket-head entry before the first
// item is accepted.
// The result sits in an output register; a stalled output holds only the last
// step of the next item.
module tolerant_vertex_weld_table #(
  parameter int unsigned BUCKETS    = tvwt_pkg::BucketsDef,
  parameter int unsigned MAX_UNIQUE = tvwt_pkg::MaxUniqueDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: coord_x [31:0], coord_y [63:32], coord_z [95:64]
  input  logic [3*tvwt_pkg::CoordW-1:0] s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: vertex_index [11:0], zero fill [15:12]
  output logic [15:0]                   m_axis_tdata,
  // tuser: is_new [0], store_full [1]
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tvwt_pkg::PaddrW-1:0]   paddr,
  input  logic [tvwt_pkg::PdataW-1:0]   pwdata,
  output logic [tvwt_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned CW     = tvwt_pkg::CoordW;
  localparam int unsigned BKT_W  = $clog2(BUCKETS);
  localparam int unsigned IDX_W  = $clog2(MAX_UNIQUE);
  localparam int unsigned HEAD_W = IDX_W + 1;
  localparam int unsigned NODE_W = HEAD_W + 3 * CW;
  localparam int unsigned HI_W   = tvwt_pkg::ProdW - tvwt_pkg::BucketLsb;

  // ---------------------------------------------------------------- config
  logic [tvwt_pkg::TolW-1:0] tol_q;
  logic [CW-1:0]             zorg_q;
  logic [31:0]               scale_q;
  logic                      cfg_wr;
  tvwt_pkg::reg_idx_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = tvwt_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= tvwt_pkg::TolRst;
      zorg_q  <= tvwt_pkg::ZOrgRst;
      scale_q <= tvwt_pkg::ScaleRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tvwt_pkg::REG_MERGE_TOL:    tol_q   <= pwdata[tvwt_pkg::TolW-1:0];
        tvwt_pkg::REG_Z_ORIGIN:     zorg_q  <= pwdata;
        tvwt_pkg::REG_BUCKET_SCALE: scale_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tvwt_pkg::REG_MERGE_TOL:    prdata = {1'b0, tol_q};
      tvwt_pkg::REG_Z_ORIGIN:     prdata = zorg_q;
      tvwt_pkg::REG_BUCKET_SCALE: prdata = scale_q;
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- state
  tvwt_pkg::state_e state_q, state_d;

  logic [BKT_W-1:0] clr_q;
  logic [IDX_W:0]   count_q;
  logic             m_valid_q;

  logic [CW-1:0]    x_q, y_q, z_q;
  logic [CW:0]      diff_q;
  logic [tvwt_pkg::ProdW-1:0] prod_q;
  logic             nonpos_q;
  logic [BKT_W-1:0] bucket_q;
  logic [HEAD_W-1:0] head_q;
  logic [IDX_W-1:0] cur_q;
  logic [IDX_W-1:0] res_idx_q;
  logic             res_new_q, res_full_q;
  logic [15:0]      m_data_q;
  logic [1:0]       m_user_q;

  // memories
  logic [HEAD_W-1:0] head_mem [BUCKETS];
  logic [NODE_W-1:0] node_mem [MAX_UNIQUE];
  logic [HEAD_W-1:0] head_rd_q;
  logic [NODE_W-1:0] node_rd_q;

  logic              head_we;
  logic [BKT_W-1:0]  head_waddr;
  logic [HEAD_W-1:0] head_wdata;
  logic              node_we;
  logic [IDX_W-1:0]  node_raddr;

  logic [BKT_W-1:0]  bucket_c;
  logic [HI_W-1:0]   prod_hi;
  logic              s_acc;
  logic              can_emit;
  logic              match;
  logic              full;
  logic              next_valid;
  logic [IDX_W-1:0]  next_idx;
  logic [IDX_W+11:0] idx_ext;

  function automatic logic near(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                input logic [tvwt_pkg::TolW-1:0] tol);
    logic [CW:0] dp;
    logic [CW:0] dn;
    dp = {a[CW-1], a} - {b[CW-1], b};
    dn = {b[CW-1], b} - {a[CW-1], a};
    // the non-negative one of the two is the magnitude
    if (dp[CW]) begin
      near = dn[CW-1:0] <= {1'b0, tol};
    end else begin
      near = dp[CW-1:0] <= {1'b0, tol};
    end
  endfunction

  assign s_acc      = s_axis_tvalid && s_axis_tready;
  assign can_emit   = !m_valid_q || m_axis_tready;
  assign full       = count_q == (IDX_W + 1)'(MAX_UNIQUE);
  assign next_valid = node_rd_q[NODE_W-1];
  assign next_idx   = node_rd_q[NODE_W-2 -: IDX_W];
  assign match      = near(node_rd_q[CW-1:0], x_q, tol_q)
                   && near(node_rd_q[2*CW-1:CW], y_q, tol_q)
                   && near(node_rd_q[3*CW-1:2*CW], z_q, tol_q);
  assign prod_hi    = prod_q[tvwt_pkg::ProdW-1:tvwt_pkg::BucketLsb];
  assign idx_ext    = {12'b0, res_idx_q};

  always_comb begin
    if (nonpos_q) begin
      bucket_c = '0;
    end else if (prod_hi > HI_W'(BUCKETS - 1)) begin
      bucket_c = BKT_W'(BUCKETS - 1);
    end else begin
      bucket_c = prod_hi[BKT_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tvwt_pkg::ST_CLEAR:  if (clr_q == BKT_W'(BUCKETS - 1)) state_d = tvwt_pkg::ST_IDLE;
      tvwt_pkg::ST_IDLE:   if (s_axis_tvalid) state_d = tvwt_pkg::ST_MUL;
      tvwt_pkg::ST_MUL:    state_d = tvwt_pkg::ST_BKT;
      tvwt_pkg::ST_BKT:    state_d = tvwt_pkg::ST_HEAD;
      tvwt_pkg::ST_HEAD: begin
        state_d = head_rd_q[IDX_W] ? tvwt_pkg::ST_WALK : tvwt_pkg::ST_INSERT;
      end
      tvwt_pkg::ST_WALK: begin
        if (match) begin
          state_d = tvwt_pkg::ST_DONE;
        end else if (!next_valid) begin
          state_d = tvwt_pkg::ST_INSERT;
        end
      end
      tvwt_pkg::ST_INSERT: state_d = tvwt_pkg::ST_DONE;
      tvwt_pkg::ST_DONE:   if (can_emit) state_d = tvwt_pkg::ST_IDLE;
      default:             state_d = tvwt_pkg::ST_CLEAR;
    endcase
  end

  // memory control
  always_comb begin
    s_axis_tready = 1'b0;
    head_we       = 1'b0;
    head_waddr    = bucket_q;
    head_wdata    = {1'b1, count_q[IDX_W-1:0]};
    node_we       = 1'b0;
    node_raddr    = next_idx;
    unique case (state_q)
      tvwt_pkg::ST_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_q;
        head_wdata = '0;
      end
      tvwt_pkg::ST_IDLE:   s_axis_tready = 1'b1;
      tvwt_pkg::ST_HEAD:   node_raddr = head_rd_q[IDX_W-1:0];
      tvwt_pkg::ST_INSERT: begin
        head_we = !full;
        node_we = !full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rd_q <= head_mem[bucket_c];
  end

  // new node links to the old chain head
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[count_q[IDX_W-1:0]] <= {head_q, z_q, y_q, x_q};
    end
    node_rd_q <= node_mem[node_raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tvwt_pkg::ST_CLEAR;
      clr_q     <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == tvwt_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == tvwt_pkg::ST_INSERT && !full) begin
        count_q <= count_q + 1'b1;
      end
      if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (state_q == tvwt_pkg::ST_DONE && can_emit) begin
        m_valid_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      x_q    <= s_axis_tdata[CW-1:0];
      y_q    <= s_axis_tdata[2*CW-1:CW];
      z_q    <= s_axis_tdata[3*CW-1:2*CW];
      diff_q <= {s_axis_tdata[3*CW-1], s_axis_tdata[3*CW-1:2*CW]} - {zorg_q[CW-1], zorg_q};
    end
    if (state_q == tvwt_pkg::ST_MUL) begin
      prod_q   <= {32'b0, diff_q[31:0]} * {32'b0, scale_q};
      nonpos_q <= diff_q[CW] || (diff_q == '0);
    end
    if (state_q == tvwt_pkg::ST_BKT) begin
      bucket_q <= bucket_c;
    end
    if (state_q == tvwt_pkg::ST_HEAD) begin
      head_q <= head_rd_q;
      cur_q  <= head_rd_q[IDX_W-1:0];
    end
    if (state_q == tvwt_pkg::ST_WALK) begin
      cur_q <= next_idx;
      if (match) begin
        res_idx_q  <= cur_q;
        res_new_q  <= 1'b0;
        res_full_q <= 1'b0;
      end
    end
    if (state_q == tvwt_pkg::ST_INSERT) begin
      res_idx_q  <= full ? '0 : count_q[IDX_W-1:0];
      res_new_q  <= !full;
      res_full_q <= full;
    end
    if (state_q == tvwt_pkg::ST_DONE && can_emit) begin
      m_data_q <= {4'b0, idx_ext[11:0]};
      m_user_q <= {res_full_q, res_new_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

>>> test/tb_tolerant_vertex_weld_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tolerant_vertex_weld_table
// Self-checking bench for the vertex weld table. A directed table covers the
// coordinate extremes, tolerance edges, bucket clamping and newest-first chain
// order. Randomized phases then run under several register settings, with
// random idles on both streams and long output stalls. Every result is compared
// against its table entry or against an in-bench model of the bucket chains.
// ----------------------------------------------------------------------------
module tb_tolerant_vertex_weld_table;
  import tvwt_pkg::*;

  localparam int unsigned Buckets     = BucketsDef;
  localparam int unsigned MaxUnique   = MaxUniqueDef;
  localparam int unsigned PhaseItems  = 150;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned NumDirected = 16;
  localparam logic [1:0]  RegUnused   = 2'd3;
  localparam longint      CoordMax    = 64'sd2147483647;
  localparam longint      CoordMin    = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } vertex_t;

  typedef struct packed {
    logic [IndexW-1:0] index;
    logic              is_new;
    logic              store_full;
  } weld_res_t;

  typedef struct packed {
    vertex_t   v;
    logic      typed;
    weld_res_t res;
  } weld_row_t;

  // Reset settings: tolerance 128, origin 0, bucket = z >> 8 (integer part of z)
  localparam weld_row_t DirectedRows [NumDirected] = '{
    '{'{32'd0, 32'd0, 32'd0},                            1'b1, '{12'd0, 1'b1, 1'b0}},
    // exactly on the tolerance in every axis
    '{'{32'd128, -32'sd128, 32'd128},                    1'b1, '{12'd0, 1'b0, 1'b0}},
    '{'{-32'sd129, 32'd0, 32'd0},                        1'b1, '{12'd1, 1'b1, 1'b0}},
    // bucket number far above the top, clamps to the last bucket
    '{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff},    1'b1, '{12'd2, 1'b1, 1'b0}},
    // below origin lands in bucket 0
    '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},    1'b1, '{12'd3, 1'b1, 1'b0}},
    '{'{32'h7fff_ffff, 32'd0, 32'd0},                    1'b1, '{12'd4, 1'b1, 1'b0}},
    // x differs by 2^32-1, a wrapped subtract would call this a match
    '{'{32'h8000_0000, 32'd0, 32'd0},                    1'b1, '{12'd5, 1'b1, 1'b0}},
    '{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ff7f},    1'b1, '{12'd2, 1'b0, 1'b0}},
    '{'{32'd1000, 32'd0, 32'd1280},                      1'b1, '{12'd6, 1'b1, 1'b0}},
    '{'{32'd1200, 32'd0, 32'd1280},                      1'b1, '{12'd7, 1'b1, 1'b0}},
    // within reach of both, newest entry wins
    '{'{32'd1100, 32'd0, 32'd1300},                      1'b1, '{12'd7, 1'b0, 1'b0}},
    // one bucket up and beyond the tolerance in z, so no weld
    '{'{32'd1000, 32'd0, 32'd1536},                      1'b1, '{12'd8, 1'b1, 1'b0}},
    '{'{-32'sd5000, 32'd12345, 32'd32767},               1'b0, '{12'd0, 1'b0, 1'b0}},
    '{'{-32'sd5000, 32'd12345, 32'd32768},               1'b0, '{12'd0, 1'b0, 1'b0}},
    '{'{32'd0, 32'd0, -32'sd1},                          1'b0, '{12'd0, 1'b0, 1'b0}},
    '{'{-32'sd128, 32'd0, 32'd0},                        1'b0, '{12'd0, 1'b0, 1'b0}}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  // tdata: coord_x [31:0], coord_y [63:32], coord_z [95:64]
  logic [3*CoordW-1:0]  s_axis_tdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // tdata: vertex_index [11:0], zero fill [15:12]
  logic [15:0]          m_axis_tdata;
  // tuser: is_new [0], store_full [1]
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PaddrW-1:0]    paddr = '0;
  logic [PdataW-1:0]    pwdata = '0;
  logic [PdataW-1:0]    prdata;
  logic                 pready;

  // bench copy of the weld table
  logic [TolW-1:0]      tol_q;
  logic [31:0]          zorg_q;
  logic [31:0]          scale_q;
  logic [IndexW-1:0]    head_idx  [Buckets];
  bit                   head_live [Buckets];
  logic [IndexW-1:0]    link_idx  [MaxUnique];
  bit                   link_live [MaxUnique];
  logic [31:0]          pos_x     [MaxUnique];
  logic [31:0]          pos_y     [MaxUnique];
  logic [31:0]          pos_z     [MaxUnique];
  int unsigned          n_stored;

  weld_res_t            pending_welds [$];
  bit                   idle_on = 1'b1;
  bit                   hold_req = 1'b0;
  int unsigned          n_errors, n_sent, n_checked, n_new, n_welded, n_full, n_settings;

  tolerant_vertex_weld_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit near_enough(logic [31:0] a, logic [31:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    if (d < 0) d = -d;
    return d <= longint'(tol_q);
  endfunction

  function automatic int unsigned z_bucket(logic [31:0] z);
    longint      diff;
    logic [63:0] prod;
    diff = longint'($signed(z)) - longint'($signed(zorg_q));
    if (diff <= 0) return 0;
    prod = (64'(diff) * {32'd0, scale_q}) >> BucketLsb;
    if (prod > 64'(Buckets - 1)) return Buckets - 1;
    return int'(prod[31:0]);
  endfunction

  // Walks the bucket chain newest first; inserts at the head when nothing welds and the store is not full.
  function automatic weld_res_t weld_vertex(vertex_t v);
    int unsigned b, cur, hops;
    bit          live;
    b    = z_bucket(v.z);
    cur  = head_idx[b];
    live = head_live[b];
    hops = 0;
    while (live && hops < MaxUnique) begin
      if (near_enough(pos_x[cur], v.x) && near_enough(pos_y[cur], v.y) &&
          near_enough(pos_z[cur], v.z)) begin
        n_welded++;
        return '{index: IndexW'(cur), is_new: 1'b0, store_full: 1'b0};
      end
      live = link_live[cur];
      cur  = link_idx[cur];
      hops++;
    end
    if (n_stored >= MaxUnique) begin
      n_full++;
      return '{index: '0, is_new: 1'b0, store_full: 1'b1};
    end
    link_idx[n_stored]  = head_idx[b];
    link_live[n_stored] = head_live[b];
    head_idx[b]         = IndexW'(n_stored);
    head_live[b]        = 1'b1;
    pos_x[n_stored]     = v.x;
    pos_y[n_stored]     = v.y;
    pos_z[n_stored]     = v.z;
    n_stored++;
    n_new++;
    return '{index: IndexW'(n_stored - 1), is_new: 1'b1, store_full: 1'b0};
  endfunction

  // Offset a stored coordinate to land on, just past, or inside the tolerance.
  function automatic logic [31:0] nudge(logic [31:0] c);
    longint t, off, v;
    t = longint'(tol_q);
    case ($urandom_range(0, 3))
      0:       off = t;
      1:       off = -t;
      2:       off = $urandom_range(0, 1) ? t + 1 : -t - 1;
      default: off = longint'($urandom_range(0, 32'(2 * t))) - t;
    endcase
    v = longint'($signed(c)) + off;
    if (v > CoordMax) v = CoordMax;
    if (v < CoordMin) v = CoordMin;
    return 32'(v);
  endfunction

  function automatic vertex_t pick_vertex();
    vertex_t     v;
    int unsigned i, pick;
    pick = $urandom_range(0, 99);
    if (n_stored != 0 && pick < 55) begin
      if (n_stored > 16 && $urandom_range(0, 1))
        i = n_stored - 1 - $urandom_range(0, 15);
      else
        i = $urandom_range(0, n_stored - 1);
      v.x = nudge(pos_x[i]);
      v.y = nudge(pos_y[i]);
      v.z = nudge(pos_z[i]);
    end else if (pick < 80) begin
      // fresh vertex near the origin, z offsets spread over all magnitudes
      v.x = 32'($signed($urandom_range(0, 65535)) - 32768);
      v.y = 32'($signed($urandom_range(0, 65535)) - 32768);
      v.z = zorg_q + ($urandom() >> $urandom_range(0, 31));
    end else begin
      v.x = $urandom();
      v.y = $urandom();
      v.z = $urandom();
    end
    return v;
  endfunction

  // Valid stays high across back-to-back transactions; only a gap or wait_results_drained lowers it.
  task automatic push_vertex(input vertex_t v, input logic typed, input weld_res_t typed_res);
    int unsigned gap;
    weld_res_t   pred;
    if (n_sent % 32 == 0) idle_on = ($urandom_range(0, 3) != 0);
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v.z, v.y, v.x};
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    pred = weld_vertex(v);
    pending_welds.push_back(typed ? typed_res : pred);
    n_sent++;
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_welds.size() != 0) @(posedge clk_i);
  endtask

  // psel stays high between back-to-back transactions; check_all_regs ends a burst
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    case (idx)
      REG_MERGE_TOL:    tol_q   = data[TolW-1:0];
      REG_Z_ORIGIN:     zorg_q  = data;
      REG_BUCKET_SCALE: scale_q = data;
      default: ;
    endcase
  endtask

  task automatic reg_check(input logic [1:0] idx, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    if (prdata !== want) begin
      $error("prdata (register %0d): expected %h, got %h", idx, want, prdata);
      n_errors++;
    end
  endtask

  task automatic check_all_regs();
    reg_check(REG_MERGE_TOL, {1'b0, tol_q});
    reg_check(REG_Z_ORIGIN, zorg_q);
    reg_check(REG_BUCKET_SCALE, scale_q);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input logic [TolW-1:0] tol, input logic [31:0] zorg,
                           input logic [31:0] scale);
    reg_write(REG_MERGE_TOL, {1'b0, tol});
    reg_write(REG_Z_ORIGIN, zorg);
    reg_write(REG_BUCKET_SCALE, scale);
    check_all_regs();
    n_settings++;
    for (int unsigned i = 0; i < PhaseItems; i++) begin
      // stall the output long enough to back up into the input
      if (i == PhaseItems / 2) hold_req = 1'b1;
      push_vertex(pick_vertex(), 1'b0, '0);
    end
    wait_results_drained();
  endtask

  initial begin : result_sink
    weld_res_t   want, got;
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (m_axis_tvalid !== 1'b1) @(posedge clk_i);
      got = '{index: m_axis_tdata[IndexW-1:0], is_new: m_axis_tuser[0],
              store_full: m_axis_tuser[1]};
      n_checked++;
      if (pending_welds.size() == 0) begin
        $error("unexpected result: vertex_index %0d is_new %0b store_full %0b",
               got.index, got.is_new, got.store_full);
        n_errors++;
      end else begin
        want = pending_welds.pop_front();
        if (got.index !== want.index) begin
          $error("vertex_index: expected %0d, got %0d", want.index, got.index);
          n_errors++;
        end
        if (got.is_new !== want.is_new) begin
          $error("is_new: expected %0b, got %0b", want.is_new, got.is_new);
          n_errors++;
        end
        if (got.store_full !== want.store_full) begin
          $error("store_full: expected %0b, got %0b", want.store_full, got.store_full);
          n_errors++;
        end
      end
    end
  end

  initial begin : stimulus
    tol_q    = TolRst;
    zorg_q   = ZOrgRst;
    scale_q  = ScaleRst;
    n_stored = 0;
    foreach (head_live[b]) head_live[b] = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[r])
      push_vertex(DirectedRows[r].v, DirectedRows[r].typed, DirectedRows[r].res);
    wait_results_drained();

    // writes past the last register must leave all three alone
    reg_write(RegUnused, $urandom());
    check_all_regs();

    run_phase(TolW'(128), 32'd0, 32'd65536);
    run_phase(TolW'(0), 32'h8000_0000, 32'hffff_ffff);
    run_phase(TolW'(31'h7fff_ffff), 32'h7fff_ffff, 32'd1);
    run_phase(TolW'(4), 32'hffff_0000, 32'd4096);
    run_phase(TolW'($urandom_range(0, 1024)), $urandom(), $urandom());
    run_phase(TolW'(255), 32'd0, 32'h0100_0000);
    run_phase(TolW'($urandom()), $urandom(), 32'd0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("weld run: %0d vertices, %0d results (%0d stored, %0d welded, %0d store-full)",
             n_sent, n_checked, n_new, n_welded, n_full);
    $display("weld run: %0d register settings incl. tolerance, origin and scale extremes",
             n_settings);
    if (n_errors == 0) begin
      $display("tb_tolerant_vertex_weld_table: clean");
    end else begin
      $display("tb_tolerant_vertex_weld_table: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("tb_tolerant_vertex_weld_table: errors");
    $finish;
  end

endmodule

>>> filelist.f
rtl/tvwt_pkg.sv
rtl/tolerant_vertex_weld_table.sv
test/tb_tolerant_vertex_weld_table.sv
